// File: rtl/core/load_cell_outlier_average_unit_defines.svh
// Assertion macros shared by the load cell outlier average unit
`ifndef LOAD_CELL_OUTLIER_AVERAGE_UNIT_DEFINES_SVH
`define LOAD_CELL_OUTLIER_AVERAGE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define LCOA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define LCOA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lcoa_pkg.sv
// Shared types and constants for the load cell outlier average unit
package lcoa_pkg;

    localparam int MAX_WINDOW = 16;
    localparam int SAMPLE_W   = 24;
    localparam int SLOT_W     = $clog2(MAX_WINDOW);
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W      = SAMPLE_W + SLOT_W;
    localparam int PROD_W     = SAMPLE_W + 7;
    localparam int RUN_W      = 3;
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [RUN_W-1:0] OUTLIER_LIMIT = RUN_W'(5);
    localparam logic [6:0]       SCALE_X       = 7'd100;
    localparam logic [6:0]       SCALE_HI      = 7'd101;
    localparam logic [6:0]       SCALE_LO      = 7'd99;

    // One classified sample on its way to the back end
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [PROD_W-1:0]          mag_scaled;
    } lcoa_item_t;

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic             negative;
        logic [SUM_W-1:0] magnitude;
        logic [LEN_W-1:0] divisor;
    } lcoa_div_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [SAMPLE_W-1:0] quotient;
    } lcoa_div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_DECIDE,
        ST_START,
        ST_DIVIDE,
        ST_DELIVER
    } lcoa_back_state_t;

    // Magnitude of a signed sample as an unsigned value
    function automatic logic [SAMPLE_W-1:0] mag24(input logic signed [SAMPLE_W-1:0] v);
        mag24 = v[SAMPLE_W-1] ? SAMPLE_W'(-v) : SAMPLE_W'(v);
    endfunction

endpackage

// File: rtl/core/lcoa_front.sv
// Front end: accept raw words, sign-extend and scale the sample magnitude
module lcoa_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // [23:0] raw_word
    output logic                        push_valid,
    input  logic                        push_ready,
    output lcoa_pkg::lcoa_item_t        push_item
);

    logic                 valid_reg;
    lcoa_pkg::lcoa_item_t item_reg;
    lcoa_pkg::lcoa_item_t item_next;
    logic signed [lcoa_pkg::SAMPLE_W-1:0] sample;

    // Take a new word when the stage is empty or drains this cycle
    assign s_tready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    // Classify: sign-extend and form |x| * 100
    always_comb begin
        sample               = $signed(s_tdata);
        item_next.sample     = sample;
        item_next.mag_scaled = lcoa_pkg::PROD_W'(lcoa_pkg::mag24(sample))
                             * lcoa_pkg::PROD_W'(lcoa_pkg::SCALE_X);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= item_next;
        end
    end

endmodule

// File: rtl/core/lcoa_queue.sv
// Two-entry queue between front and back ends
module lcoa_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  lcoa_pkg::lcoa_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output lcoa_pkg::lcoa_item_t pop_item
);

    lcoa_pkg::lcoa_item_t entry_reg [2];
    logic [1:0] count_reg;
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            priority if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end else begin
                count_reg <= count_reg;
            end
        end
    end

    // Hold entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/core/lcoa_divider.sv
// Restoring divider: window sum by window length, one quotient bit per cycle
module lcoa_divider (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  lcoa_pkg::lcoa_div_req_t req,
    output lcoa_pkg::lcoa_div_rsp_t rsp
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [lcoa_pkg::DIV_CNT_W-1:0]   count_reg;
    logic [lcoa_pkg::LEN_W:0]         rem_reg;
    logic [lcoa_pkg::SUM_W-1:0]       quo_reg;
    logic                             neg_reg;
    logic [lcoa_pkg::LEN_W-1:0]       div_reg;
    logic [lcoa_pkg::LEN_W:0]         rem_shift;
    logic                             fits;
    logic [lcoa_pkg::SAMPLE_W-1:0]    quo_low;

    // One restoring step
    always_comb begin
        rem_shift = {rem_reg[lcoa_pkg::LEN_W-1:0], quo_reg[lcoa_pkg::SUM_W-1]};
        fits      = (rem_shift >= {1'b0, div_reg});
    end

    // Apply the sign to the quotient magnitude
    assign quo_low      = quo_reg[lcoa_pkg::SAMPLE_W-1:0];
    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? $signed(-quo_low) : $signed(quo_low);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg &&
                         count_reg == lcoa_pkg::DIV_CNT_W'(lcoa_pkg::DIV_STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            count_reg <= '0;
            rem_reg   <= '0;
            quo_reg   <= req.magnitude;
            neg_reg   <= req.negative;
            div_reg   <= req.divisor;
        end else if (busy_reg) begin
            count_reg <= count_reg + 1'b1;
            rem_reg   <= fits ? rem_shift - {1'b0, div_reg} : rem_shift;
            quo_reg   <= {quo_reg[lcoa_pkg::SUM_W-2:0], fits};
        end
    end

endmodule

// File: rtl/core/lcoa_back.sv
// Back end: outlier decision, window ring and running sum, mean and result register
`include "load_cell_outlier_average_unit_defines.svh"

module lcoa_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic [4:0]                   cfg_data,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  lcoa_pkg::lcoa_item_t         pop_item,
    output lcoa_pkg::lcoa_div_req_t      div_req,
    input  lcoa_pkg::lcoa_div_rsp_t      div_rsp,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [47:0]                  m_tdata,
    output logic [0:0]                   m_tuser
);

    lcoa_pkg::lcoa_back_state_t state_reg, state_next;

    logic [lcoa_pkg::LEN_W-1:0]           len_reg;
    logic [lcoa_pkg::LEN_W-1:0]           len_next;
    logic [lcoa_pkg::SLOT_W-1:0]          slot_reg;
    logic [lcoa_pkg::RUN_W-1:0]           run_reg;
    logic [lcoa_pkg::MAX_WINDOW-1:0]      valid_reg;
    logic signed [lcoa_pkg::SAMPLE_W-1:0] store_reg [lcoa_pkg::MAX_WINDOW];
    logic signed [lcoa_pkg::SUM_W-1:0]    sum_reg;
    logic signed [lcoa_pkg::SAMPLE_W-1:0] mean_reg;
    lcoa_pkg::lcoa_item_t                 item_reg;
    logic                                 acc_reg;
    logic [lcoa_pkg::PROD_W-1:0]          hi_reg;
    logic [lcoa_pkg::PROD_W-1:0]          lo_reg;

    logic                                 out_valid_reg;
    logic signed [lcoa_pkg::SAMPLE_W-1:0] out_sample_reg;
    logic signed [lcoa_pkg::SAMPLE_W-1:0] out_mean_reg;
    logic                                 out_acc_reg;

    logic                                 load_out;
    logic                                 start_div;
    logic                                 outlier;
    logic [lcoa_pkg::RUN_W-1:0]           run_inc;
    logic                                 keep;
    logic signed [lcoa_pkg::SAMPLE_W-1:0] old_entry;
    logic [lcoa_pkg::LEN_W-1:0]           slot_inc;
    logic [lcoa_pkg::SAMPLE_W-1:0]        mean_mag;

    // Saturate the written window length
    assign len_next = (cfg_data > lcoa_pkg::LEN_W'(lcoa_pkg::MAX_WINDOW))
                    ? lcoa_pkg::LEN_W'(lcoa_pkg::MAX_WINDOW) : cfg_data;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lcoa_pkg::ST_IDLE:    if (pop_valid) state_next = lcoa_pkg::ST_SCALE;
            lcoa_pkg::ST_SCALE: begin
                state_next = (len_reg == '0) ? lcoa_pkg::ST_DELIVER : lcoa_pkg::ST_DECIDE;
            end
            lcoa_pkg::ST_DECIDE:  state_next = lcoa_pkg::ST_START;
            lcoa_pkg::ST_START:   state_next = lcoa_pkg::ST_DIVIDE;
            lcoa_pkg::ST_DIVIDE:  if (div_rsp.done) state_next = lcoa_pkg::ST_DELIVER;
            lcoa_pkg::ST_DELIVER: if (load_out) state_next = lcoa_pkg::ST_IDLE;
            default:              state_next = lcoa_pkg::ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        pop_ready = 1'b0;
        start_div = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            lcoa_pkg::ST_IDLE:    pop_ready = 1'b1;
            lcoa_pkg::ST_START:   start_div = 1'b1;
            lcoa_pkg::ST_DELIVER: load_out  = !out_valid_reg || m_tready;
            default: ;
        endcase
    end

    // Outlier decision against the pre-update mean
    always_comb begin
        outlier   = (item_reg.mag_scaled > hi_reg) || (item_reg.mag_scaled < lo_reg);
        run_inc   = run_reg + 1'b1;
        keep      = !outlier || (run_inc >= lcoa_pkg::OUTLIER_LIMIT);
        old_entry = valid_reg[slot_reg] ? store_reg[slot_reg] : '0;
        slot_inc  = {1'b0, slot_reg} + 1'b1;
        mean_mag  = lcoa_pkg::mag24(mean_reg);
    end

    // Divider request from the updated sum
    always_comb begin
        div_req.start     = start_div;
        div_req.negative  = sum_reg[lcoa_pkg::SUM_W-1];
        div_req.magnitude = sum_reg[lcoa_pkg::SUM_W-1] ? lcoa_pkg::SUM_W'(-sum_reg)
                                                       : lcoa_pkg::SUM_W'(sum_reg);
        div_req.divisor   = len_reg;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_mean_reg, out_sample_reg};
    assign m_tuser[0] = out_acc_reg;

    // Control state, window bookkeeping and config clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lcoa_pkg::ST_IDLE;
            len_reg       <= '0;
            slot_reg      <= '0;
            run_reg       <= '0;
            valid_reg     <= '0;
            sum_reg       <= '0;
            mean_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid) begin
                len_reg   <= len_next;
                slot_reg  <= '0;
                valid_reg <= '0;
                sum_reg   <= '0;
                mean_reg  <= '0;
            end else if (state_reg == lcoa_pkg::ST_DECIDE) begin
                if (keep) begin
                    run_reg             <= '0;
                    valid_reg[slot_reg] <= 1'b1;
                    sum_reg             <= sum_reg - lcoa_pkg::SUM_W'(old_entry)
                                         + lcoa_pkg::SUM_W'(item_reg.sample);
                    slot_reg            <= (slot_inc >= len_reg) ? '0
                                         : slot_inc[lcoa_pkg::SLOT_W-1:0];
                end else begin
                    run_reg <= run_inc;
                end
            end else if (state_reg == lcoa_pkg::ST_DIVIDE && div_rsp.done) begin
                mean_reg <= div_rsp.quotient;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (pop_valid && pop_ready) begin
            item_reg <= pop_item;
            acc_reg  <= 1'b0;
        end
        if (state_reg == lcoa_pkg::ST_SCALE) begin
            hi_reg <= lcoa_pkg::PROD_W'(mean_mag) * lcoa_pkg::PROD_W'(lcoa_pkg::SCALE_HI);
            lo_reg <= lcoa_pkg::PROD_W'(mean_mag) * lcoa_pkg::PROD_W'(lcoa_pkg::SCALE_LO);
        end
        if (state_reg == lcoa_pkg::ST_DECIDE) begin
            acc_reg <= keep;
            if (keep) begin
                store_reg[slot_reg] <= item_reg.sample;
            end
        end
        if (load_out) begin
            out_sample_reg <= item_reg.sample;
            out_mean_reg   <= mean_reg;
            out_acc_reg    <= acc_reg;
        end
    end

    `LCOA_ASSERT_NOW(a_slot_in_window, aclk, aresetn, len_reg != '0,
        {1'b0, slot_reg} < len_reg, "write slot outside window")
    `LCOA_ASSERT_NOW(a_run_bounded, aclk, aresetn, 1'b1,
        run_reg < lcoa_pkg::OUTLIER_LIMIT, "outlier run past limit")
    `LCOA_ASSERT_NOW(a_done_in_divide, aclk, aresetn, div_rsp.done,
        state_reg == lcoa_pkg::ST_DIVIDE, "divider finished outside divide state")
    `LCOA_ASSERT_NOW(a_disabled_result, aclk, aresetn, load_out && len_reg == '0,
        !acc_reg && mean_reg == '0, "disabled window gave nonzero result")
    `LCOA_ASSERT_NEXT(a_cfg_clears, aclk, aresetn, cfg_valid,
        sum_reg == '0 && mean_reg == '0 && slot_reg == '0, "config did not clear window")

endmodule

// File: rtl/core/load_cell_outlier_average_unit.sv
// Load cell moving average with outlier rejection, top level
// Path from input word to result word: front stage, queue, scale, decide, divider
//   start, restoring divide, result register (length 0: scale, then result).
// The back end takes one word at a time; later words wait in the front and queue.
// Reset (aresetn low, synchronous): window length 0, window empty, slot and
//   outlier run zero, no result pending; a length write empties the window.
module load_cell_outlier_average_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,   // [4:0] window_length
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // [23:0] raw_word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [23:0] sample_value, [47:24] window_mean
    output logic [0:0]  m_tuser     // [0] accepted
);

    logic                    push_valid;
    logic                    push_ready;
    lcoa_pkg::lcoa_item_t    push_item;
    logic                    pop_valid;
    logic                    pop_ready;
    lcoa_pkg::lcoa_item_t    pop_item;
    lcoa_pkg::lcoa_div_req_t div_req;
    lcoa_pkg::lcoa_div_rsp_t div_rsp;

    assign cfg_ready = 1'b1;

    lcoa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    lcoa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    lcoa_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    lcoa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
